FILE: src/tctm_pkg.sv
// Shared constants for the tempo curve trigger map.
package tctm_pkg;

  localparam int unsigned KNOB_W      = 8;
  localparam int unsigned KNOB_COUNT  = 4;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned IDX_OUT_W   = 5;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned BASE_RATE   = 128;
  localparam int unsigned RESET_STEPS = 16;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 24;

endpackage

FILE: src/tempo_curve_trigger_map.sv
// Tempo curve trigger map: builds trigger positions from four knob readings.
// Steps: one rate pass over all steps, a read and a write per step to normalize, then per
// step one read, one load, a bit-serial restoring divide to a 16-bit quotient and one emit.
// One request is taken per run; the output can stall the emit of each step.
// The next request is taken once the last result sits in the output register.
// Reset clears control state and sets the step count to 16; the scratch memory is not cleared.
module tempo_curve_trigger_map #(
  parameter int unsigned MAX_STEPS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tctm_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: knob_a, knob_b, knob_c, knob_d.
  input  logic [tctm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0 up: step_index, trigger_position, three zero bits.
  output logic [tctm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast
);

  localparam int unsigned IDX_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_STEPS + 1);
  localparam int unsigned RATE_W = $clog2((MAX_STEPS + 1) * 256) + 1;
  localparam int unsigned DIST_W = $clog2(MAX_STEPS * (MAX_STEPS + 2) * 256) + 1;
  localparam int unsigned NUM_W  = DIST_W + tctm_pkg::POS_W;
  localparam int unsigned DCNT_W = $clog2(tctm_pkg::POS_W);
  localparam int unsigned SEL_W  = CNT_W + 2;

  typedef enum logic [2:0] {
    StIdle,
    StRate,
    StNrmRd,
    StNrmWr,
    StDivRd,
    StDivLd,
    StDiv,
    StEmit
  } state_e;

  state_e                           state_q;
  logic [tctm_pkg::CFG_W-1:0]       steps_q;
  logic [tctm_pkg::KNOB_W-1:0]      knob_q [tctm_pkg::KNOB_COUNT];
  logic [IDX_W-1:0]                 idx_q;
  logic signed [RATE_W-1:0]         rate_q;
  logic signed [RATE_W-1:0]         min_q;
  logic [DIST_W-1:0]                dist_q;
  logic [DIST_W-1:0]                rem_q;
  logic [tctm_pkg::POS_W-1:0]       num_q;
  logic [tctm_pkg::POS_W-1:0]       quo_q;
  logic [DCNT_W-1:0]                dcnt_q;
  logic                             out_valid_q;
  logic                             out_last_q;
  logic [tctm_pkg::IDX_OUT_W-1:0]   out_idx_q;
  logic [tctm_pkg::POS_W-1:0]       out_pos_q;

  logic [DIST_W-1:0]                mem_q [MAX_STEPS];
  logic [DIST_W-1:0]                rd_q;
  logic                             mem_we;
  logic [DIST_W-1:0]                mem_wdata;

  logic [CNT_W-1:0]                 n_w;
  logic                             last_w;
  logic [SEL_W-1:0]                 i4_w;
  logic [SEL_W-1:0]                 n1_w;
  logic [SEL_W-1:0]                 n2_w;
  logic [SEL_W-1:0]                 n3_w;
  logic [1:0]                       sel_w;
  logic signed [9:0]                delta_w;
  logic signed [RATE_W-1:0]         rate_next_w;
  logic signed [RATE_W:0]           norm_w;
  logic [NUM_W-1:0]                 numer_w;
  logic [DIST_W:0]                  trial_w;
  logic                             fit_w;
  logic                             out_free_w;
  logic                             emit_w;

  always_comb begin
    if (steps_q == '0) begin
      n_w = CNT_W'(1);
    end else if ({1'b0, steps_q} > 7'(MAX_STEPS)) begin
      n_w = CNT_W'(MAX_STEPS);
    end else begin
      n_w = CNT_W'(steps_q);
    end
    last_w = ((CNT_W'(idx_q) + CNT_W'(1)) == n_w);
    i4_w = {CNT_W'(idx_q), 2'b00};
    n1_w = SEL_W'(n_w);
    n2_w = SEL_W'(n_w) << 1;
    n3_w = n1_w + n2_w;
    sel_w = 2'(i4_w >= n1_w) + 2'(i4_w >= n2_w) + 2'(i4_w >= n3_w);
    delta_w = 10'sd128 - $signed({2'b00, knob_q[sel_w]});
    rate_next_w = rate_q + RATE_W'(delta_w);
    norm_w = (RATE_W + 1)'($signed(rd_q[RATE_W-1:0])) - (RATE_W + 1)'(min_q)
           + (RATE_W + 1)'(tctm_pkg::BASE_RATE);
    numer_w = {rd_q, {tctm_pkg::POS_W{1'b0}}} - NUM_W'(rd_q);
    trial_w = {rem_q, num_q[tctm_pkg::POS_W-1]};
    fit_w = (trial_w >= {1'b0, dist_q});
    out_free_w = !out_valid_q || m_axis_tready;
    emit_w = (state_q == StEmit) && out_free_w;
    mem_we = (state_q == StRate) || (state_q == StNrmWr);
    if (state_q == StRate) begin
      mem_wdata = DIST_W'(rate_q);
    end else begin
      mem_wdata = dist_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      steps_q     <= tctm_pkg::CFG_W'(tctm_pkg::RESET_STEPS);
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      dcnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        steps_q <= cfg_wdata_i;
      end
      if (m_axis_tready && !emit_w) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            for (int k = 0; k < tctm_pkg::KNOB_COUNT; k++) begin
              knob_q[k] <= s_axis_tdata[k*tctm_pkg::KNOB_W +: tctm_pkg::KNOB_W];
            end
            rate_q  <= RATE_W'(tctm_pkg::BASE_RATE);
            min_q   <= RATE_W'(tctm_pkg::BASE_RATE);
            idx_q   <= '0;
            state_q <= StRate;
          end
        end
        StRate: begin
          rate_q <= rate_next_w;
          if (rate_next_w < min_q) begin
            min_q <= rate_next_w;
          end
          if (last_w) begin
            idx_q   <= '0;
            dist_q  <= '0;
            state_q <= StNrmRd;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        StNrmRd: begin
          state_q <= StNrmWr;
        end
        StNrmWr: begin
          dist_q <= dist_q + DIST_W'(norm_w);
          if (last_w) begin
            idx_q   <= '0;
            state_q <= StDivRd;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= StNrmRd;
          end
        end
        StDivRd: begin
          state_q <= StDivLd;
        end
        StDivLd: begin
          rem_q   <= numer_w[NUM_W-1:tctm_pkg::POS_W];
          num_q   <= numer_w[tctm_pkg::POS_W-1:0];
          dcnt_q  <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          if (fit_w) begin
            rem_q <= DIST_W'(trial_w - {1'b0, dist_q});
          end else begin
            rem_q <= DIST_W'(trial_w);
          end
          num_q  <= num_q << 1;
          quo_q  <= {quo_q[tctm_pkg::POS_W-2:0], fit_w};
          dcnt_q <= dcnt_q + DCNT_W'(1);
          if (dcnt_q == DCNT_W'(tctm_pkg::POS_W - 1)) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free_w) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= tctm_pkg::IDX_OUT_W'(idx_q);
            out_pos_q   <= quo_q;
            out_last_q  <= last_w;
            if (last_w) begin
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= StDivRd;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, out_pos_q, out_idx_q};

  // The divider remainder always stays below the total distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < dist_q))
    else $error("divider remainder not below total");

  // A divide stays in its divide state until its 16-bit quotient is done, then hands it to the emit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |=> ((state_q == StDiv) || (state_q == StEmit)))
    else $error("divider left early");

  // An accepted request always starts the rate pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == StRate))
    else $error("accepted request did not start the rate pass");

endmodule

FILE: verif/tempo_curve_trigger_map_test.sv
// Self-checking testbench for the tempo curve trigger map with random stalls on both streams.
module tempo_curve_trigger_map_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_STEPS = 32;
  localparam int BASE = tctm_pkg::BASE_RATE;
  localparam longint FULL_SCALE = 65535;
  localparam int IDLE_PCT = 27;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [tctm_pkg::IDX_OUT_W-1:0] step_index;
    logic [tctm_pkg::POS_W-1:0]     position;
    logic                           last_step;
  } trigger_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tctm_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [tctm_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [tctm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  logic [tctm_pkg::IN_DATA_W-1:0] knob_queue[$];
  trigger_t expected_triggers[$];
  logic [tctm_pkg::CFG_W-1:0] step_setting = tctm_pkg::CFG_W'(tctm_pkg::RESET_STEPS);
  logic request_taken = 1'b0;
  logic steady = 1'b0;
  int hold_asks = 0;
  int errors = 0;
  int requests_sent = 0;
  int triggers_checked = 0;
  int stall_count = 0;

  tempo_curve_trigger_map #(
    .MAX_STEPS(MAX_STEPS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void map_triggers(input logic [tctm_pkg::IN_DATA_W-1:0] knobs);
    int rec[MAX_STEPS];
    longint dist_at[MAX_STEPS];
    int steps;
    int rate;
    int low;
    int sel;
    longint span;
    longint posn;
    trigger_t t;
    steps = (step_setting == 0) ? 1 : ((step_setting > MAX_STEPS) ? MAX_STEPS : int'(step_setting));
    rate = BASE;
    low = BASE;
    for (int i = 0; i < steps; i++) begin
      sel = (i * tctm_pkg::KNOB_COUNT) / steps;
      rec[i] = rate;
      rate = rate + BASE - int'(knobs[tctm_pkg::KNOB_W*sel +: tctm_pkg::KNOB_W]);
      if (rate < low) begin
        low = rate;
      end
    end
    span = 0;
    for (int i = 0; i < steps; i++) begin
      dist_at[i] = span;
      span = span + rec[i] - low + BASE;
    end
    for (int i = 0; i < steps; i++) begin
      posn = (span > 0) ? (FULL_SCALE * dist_at[i]) / span : 0;
      t.step_index = i[tctm_pkg::IDX_OUT_W-1:0];
      t.position = posn[tctm_pkg::POS_W-1:0];
      t.last_step = (i == steps - 1);
      expected_triggers.push_back(t);
    end
  endfunction

  // Request side: accepted requests are predicted at the rising edge.
  always @(posedge clk_i) begin
    request_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      map_triggers(s_axis_tdata);
      requests_sent++;
    end
  end

  always @(negedge clk_i) begin
    logic next_valid;
    logic [tctm_pkg::IN_DATA_W-1:0] next_data;
    next_valid = s_axis_tvalid;
    next_data = s_axis_tdata;
    if (rst_ni && (!s_axis_tvalid || request_taken)) begin
      next_valid = 1'b0;
      if (knob_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        next_valid = 1'b1;
        next_data = knob_queue.pop_front();
      end
    end
    s_axis_tvalid <= next_valid;
    s_axis_tdata <= next_data;
  end

  // Result side: the hold-off counter lives in this process only.
  always @(negedge clk_i) begin
    int hold_seen;
    int hold_left;
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    trigger_t want;
    logic [tctm_pkg::IDX_OUT_W-1:0] got_index;
    logic [tctm_pkg::POS_W-1:0] got_pos;
    logic [2:0] got_pad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_index = m_axis_tdata[tctm_pkg::IDX_OUT_W-1:0];
      got_pos = m_axis_tdata[tctm_pkg::IDX_OUT_W +: tctm_pkg::POS_W];
      got_pad = m_axis_tdata[tctm_pkg::OUT_DATA_W-1 -: 3];
      if (expected_triggers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result index %0d position %0d last %0b",
                 $realtime, got_index, got_pos, m_axis_tlast);
      end else begin
        want = expected_triggers.pop_front();
        triggers_checked++;
        if (got_index !== want.step_index) begin
          errors++;
          $display("%0t: step index expected %0d actual %0d",
                   $realtime, want.step_index, got_index);
        end
        if (got_pos !== want.position) begin
          errors++;
          $display("%0t: position of step %0d expected %0d actual %0d",
                   $realtime, want.step_index, want.position, got_pos);
        end
        if (m_axis_tlast !== want.last_step) begin
          errors++;
          $display("%0t: last flag of step %0d expected %0b actual %0b",
                   $realtime, want.step_index, want.last_step, m_axis_tlast);
        end
        if (got_pad !== 3'b000) begin
          errors++;
          $display("%0t: padding bits expected 0 actual %0b", $realtime, got_pad);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic wait_for_drain();
    while (knob_queue.size() != 0 || s_axis_tvalid || expected_triggers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_steps(input logic [tctm_pkg::CFG_W-1:0] value);
    wait_for_drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    step_setting = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [tctm_pkg::IN_DATA_W-1:0] random_knobs();
    logic [7:0] k;
    case ($urandom_range(5))
      0: begin
        k = 8'($urandom_range(255));
        return {k, k, k, k};
      end
      1: return {4{8'(($urandom_range(1) != 0) ? 8'hFF : 8'h00)}};
      2: return {8'($urandom_range(255)), 8'hFF, 8'h00, 8'($urandom_range(255))};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [tctm_pkg::CFG_W-1:0] corner_steps[8];
    logic [tctm_pkg::CFG_W-1:0] pick;
    corner_steps = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd5, 6'd32, 6'd33, 6'd63};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset step count of 16 with extreme and flat knob settings.
    knob_queue.push_back(32'h0000_0000);
    knob_queue.push_back(32'hFFFF_FFFF);
    knob_queue.push_back(32'h8080_8080);
    knob_queue.push_back(32'h00FF_00FF);
    knob_queue.push_back(32'hFF00_FF00);
    knob_queue.push_back(32'h0000_00FF);
    knob_queue.push_back(32'hFF00_0000);
    knob_queue.push_back(32'h7F81_017E);

    // Zero, single, small, full and saturating step counts.
    foreach (corner_steps[i]) begin
      write_steps(corner_steps[i]);
      knob_queue.push_back(32'h0000_0000);
      knob_queue.push_back(32'hFFFF_FFFF);
    end

    // The receiver holds off while requests keep coming, so the input backs up.
    write_steps(6'd4);
    repeat (6) knob_queue.push_back($urandom);
    @(negedge clk_i);
    hold_asks++;

    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(9))
        0: pick = 6'd0;
        1: pick = 6'd32;
        2: pick = 6'($urandom_range(63));
        3: pick = 6'd63;
        default: pick = 6'($urandom_range(12, 1));
      endcase
      write_steps(pick);
      steady = (phase == 5);
      repeat (22) knob_queue.push_back(random_knobs());
    end

    wait_for_drain();
    steady = 1'b0;
    repeat (40) @(posedge clk_i);
    if (expected_triggers.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $realtime, expected_triggers.size());
    end
    $display("Sent %0d knob requests over step counts 0 to 63 and checked %0d trigger positions.",
             requests_sent, triggers_checked);
    $display("Stalls on both streams included a long output hold-off and a stretch without gaps.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
